/* hdl/ccs_pkg.sv */
// Shared types and constants of the codebook cosine similarity core.
package ccs_pkg;

	localparam int ACC_W = 48;
	localparam int VAL_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	typedef struct packed {
		logic [ACC_W-1:0] dot;
		logic [ACC_W-1:0] na;
		logic [ACC_W-1:0] nb;
	} sums_t;

	typedef struct packed {
		logic  empty;
		logic  [QCNT_W-1:0] cnt;
		sums_t head;
	} q_stat_t;

endpackage

/* hdl/ccs_front.sv */
// Front end: codebook storage, lookup, products and accumulation of one vector pair.
module ccs_front #(
	parameter int CODEBOOK_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic func,
	input  logic [7:0] entry_index,
	input  logic signed [15:0] entry_value,
	input  logic [7:0] code_a,
	input  logic [7:0] code_b,
	input  logic last,
	output logic q_push,
	output ccs_pkg::sums_t q_data,
	input  ccs_pkg::q_stat_t q_stat
);
	import ccs_pkg::*;

	localparam int AW = $clog2(CODEBOOK_DEPTH);

	logic signed [VAL_W-1:0] mem [CODEBOOK_DEPTH];
	logic accept;
	logic signed [VAL_W-1:0] rd_a_s1, rd_b_s1, va, vb;
	logic ok_a_s1, ok_b_s1, valid_s1, last_s1;
	logic signed [31:0] pab_s2, paa_s2, pbb_s2;
	logic valid_s2, last_s2;
	sums_t acc_q, sum;
	logic [QCNT_W:0] pend;

	assign pend = {1'b0, q_stat.cnt} + (QCNT_W + 1)'(last_s1) + (QCNT_W + 1)'(last_s2);
	assign full = pend >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	always_ff @(posedge clk) begin
		if (accept && !func && ({1'b0, entry_index} < 9'(CODEBOOK_DEPTH)))
			mem[entry_index[AW-1:0]] <= entry_value;
		if (accept && func) begin
			rd_a_s1 <= mem[code_a[AW-1:0]];
			rd_b_s1 <= mem[code_b[AW-1:0]];
			ok_a_s1 <= {1'b0, code_a} < 9'(CODEBOOK_DEPTH);
			ok_b_s1 <= {1'b0, code_b} < 9'(CODEBOOK_DEPTH);
		end
	end

	assign va = ok_a_s1 ? rd_a_s1 : '0;
	assign vb = ok_b_s1 ? rd_b_s1 : '0;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pab_s2 <= va * vb;
			paa_s2 <= va * va;
			pbb_s2 <= vb * vb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && func;
			last_s1 <= accept && func && last;
			valid_s2 <= valid_s1;
			last_s2 <= last_s1;
		end
	end

	assign sum.dot = acc_q.dot + {{(ACC_W - 32){pab_s2[31]}}, pab_s2};
	assign sum.na = acc_q.na + {{(ACC_W - 32){1'b0}}, paa_s2};
	assign sum.nb = acc_q.nb + {{(ACC_W - 32){1'b0}}, pbb_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= last_s2 ? '0 : sum;
		end
	end

	assign q_push = valid_s2 && last_s2;
	assign q_data = sum;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_stat.cnt < QCNT_W'(QUEUE_DEPTH)) else $error("queue overrun");
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2) else $error("product stage lost a pair");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |=> (acc_q.dot == '0 && acc_q.na == '0 && acc_q.nb == '0))
		else $error("sums not cleared after last pair");

endmodule

/* hdl/ccs_fifo.sv */
// Short queue of finished sums between front and back end.
module ccs_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  ccs_pkg::sums_t wdata,
	input  logic rd,
	output ccs_pkg::q_stat_t stat
);
	import ccs_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	sums_t buf_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr)
			buf_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
		end
	end

	assign stat.empty = cnt_q == '0;
	assign stat.cnt = cnt_q;
	assign stat.head = buf_q[rp_q];

endmodule

/* hdl/ccs_back.sv */
// Back end: norm product, bitwise search of the rounded ratio, result register.
module ccs_back (
	input  logic clk,
	input  logic arst_n,
	input  ccs_pkg::q_stat_t q_stat,
	output logic q_rd,
	output logic empty,
	input  logic pop,
	output logic signed [15:0] similarity,
	output logic degenerate
);
	import ccs_pkg::*;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_MULP = 7'b0000010,
		B_MULR = 7'b0000100,
		B_KSQ  = 7'b0001000,
		B_MULT = 7'b0010000,
		B_OUT  = 7'b0100000,
		B_HOLD = 7'b1000000
	} bst_t;

	bst_t st_q;
	logic [127:0] mc_q, acc_q, r_q;
	logic [47:0] mp_q, mag_q;
	logic [95:0] p_q;
	logic neg_q, deg_q, res_valid_q, res_deg_q;
	logic [14:0] qv_q, cand_q, cand;
	logic [3:0] bit_q;
	logic [15:0] kk;
	logic [29:0] k2;
	logic signed [15:0] res_sim_q;
	logic signed [ACC_W-1:0] dot_s;

	assign dot_s = q_stat.head.dot;
	assign cand = qv_q | (15'd1 << bit_q);
	assign kk = {cand, 1'b0} - 16'd1;
	assign k2 = kk[14:0] * kk[14:0];
	assign q_rd = (st_q == B_IDLE) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q)
				res_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						neg_q <= dot_s[ACC_W-1];
						mag_q <= dot_s[ACC_W-1] ? 48'(-dot_s) : 48'(dot_s);
						qv_q <= '0;
						if (q_stat.head.na == '0 || q_stat.head.nb == '0) begin
							deg_q <= 1'b1;
							st_q <= B_OUT;
						end else begin
							deg_q <= 1'b0;
							mc_q <= 128'(q_stat.head.na);
							mp_q <= q_stat.head.nb;
							acc_q <= '0;
							st_q <= B_MULP;
						end
					end
				end
				B_MULP, B_MULR, B_MULT: begin
					if (mp_q == '0) begin
						acc_q <= '0;
						if (st_q == B_MULP) begin
							p_q <= acc_q[95:0];
							mc_q <= 128'(mag_q);
							mp_q <= mag_q;
							st_q <= B_MULR;
						end else if (st_q == B_MULR) begin
							r_q <= acc_q << 30;
							bit_q <= 4'd14;
							st_q <= B_KSQ;
						end else begin
							if (acc_q <= r_q)
								qv_q <= cand_q;
							bit_q <= bit_q - 4'd1;
							st_q <= (bit_q == '0) ? B_OUT : B_KSQ;
						end
					end else begin
						if (mp_q[0])
							acc_q <= acc_q + mc_q;
						mc_q <= mc_q << 1;
						mp_q <= mp_q >> 1;
					end
				end
				B_KSQ: begin
					if (cand > ONE_Q14) begin
						bit_q <= bit_q - 4'd1;
						st_q <= (bit_q == '0) ? B_OUT : B_KSQ;
					end else begin
						cand_q <= cand;
						mc_q <= 128'(p_q);
						mp_q <= 48'(k2);
						acc_q <= '0;
						st_q <= B_MULT;
					end
				end
				B_OUT: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						res_deg_q <= deg_q;
						res_sim_q <= neg_q ? 16'd0 - {1'b0, qv_q} : {1'b0, qv_q};
						st_q <= B_IDLE;
					end
				end
				B_HOLD: st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign empty = !res_valid_q;
	assign similarity = res_sim_q;
	assign degenerate = res_deg_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_OUT && res_valid_q && !pop) |=> st_q == B_OUT)
		else $error("result overwritten");
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_deg_q) |-> res_sim_q == '0) else $error("degenerate not zero");
	a_cand: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_MULT |-> cand_q <= ONE_Q14) else $error("candidate above one");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_MULT && mp_q == '0 && acc_q <= r_q) |=> qv_q == $past(cand_q))
		else $error("accepted candidate lost");

endmodule

/* hdl/codebook_cosine_similarity_core.sv */
// Codebook cosine similarity core: top level.
// Pairs stream in at one per cycle while the sums queue has room. The back end
// computes each result with its shared shift-add multiplier, and it takes the next
// sums from the queue only when it is idle.
// Reset clears sums, pipeline, queue and result; the codebook is not cleared.
module codebook_cosine_similarity_core #(
	parameter int CODEBOOK_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic func,
	input  logic [7:0] entry_index,
	input  logic signed [15:0] entry_value,
	input  logic [7:0] code_a,
	input  logic [7:0] code_b,
	input  logic last,
	output logic empty,
	input  logic pop,
	output logic signed [15:0] similarity,
	output logic degenerate
);
	import ccs_pkg::*;

	logic q_push, q_rd;
	sums_t q_data;
	q_stat_t q_stat;

	ccs_front #(.CODEBOOK_DEPTH(CODEBOOK_DEPTH)) u_front (
		.clk, .arst_n, .push, .full, .func, .entry_index, .entry_value,
		.code_a, .code_b, .last, .q_push, .q_data, .q_stat
	);

	ccs_fifo u_fifo (
		.clk, .arst_n, .wr(q_push), .wdata(q_data), .rd(q_rd), .stat(q_stat)
	);

	ccs_back u_back (
		.clk, .arst_n, .q_stat, .q_rd, .empty, .pop, .similarity, .degenerate
	);

endmodule

/* tb/tb_codebook_cosine_similarity_core.sv */
// Testbench for the codebook cosine similarity core, checked against a predictor.
class ccs_scoreboard;
	typedef struct {
		logic signed [15:0] similarity;
		logic degenerate;
	} result_t;

	logic signed [15:0] codebook [256];
	logic [47:0] dot_acc, norm_a_acc, norm_b_acc;
	result_t pending [$];
	int errors, results_seen, degenerate_seen, saturated_seen;

	function new();
		dot_acc = '0;
		norm_a_acc = '0;
		norm_b_acc = '0;
		errors = 0;
		results_seen = 0;
		degenerate_seen = 0;
		saturated_seen = 0;
		foreach (codebook[i]) codebook[i] = '0;
	endfunction

	// round(2^14 * mag / sqrt(prod)), saturated at one
	function automatic logic [15:0] cos_q14(logic [47:0] mag, logic [95:0] prod);
		logic [191:0] m, rhs, lhs, k;
		int lo, hi, mid;
		m = {144'd0, mag} << 15;
		rhs = m * m;
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			k = 2 * mid - 1;
			lhs = {96'd0, prod} * k * k;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo[15:0];
	endfunction

	function void note_request(logic func, logic [7:0] idx, logic signed [15:0] val,
			logic [7:0] ca, logic [7:0] cb, logic lst);
		logic signed [31:0] pa, pb, pab;
		logic signed [47:0] dot;
		logic [47:0] mag;
		logic [95:0] prod;
		logic [15:0] q;
		result_t r;
		if (!func) begin
			codebook[idx] = val;
			return;
		end
		pab = codebook[ca] * codebook[cb];
		pa = codebook[ca] * codebook[ca];
		pb = codebook[cb] * codebook[cb];
		dot_acc = dot_acc + {{16{pab[31]}}, pab};
		norm_a_acc = norm_a_acc + {16'd0, pa};
		norm_b_acc = norm_b_acc + {16'd0, pb};
		if (!lst) return;
		if (norm_a_acc == 0 || norm_b_acc == 0) begin
			r.similarity = '0;
			r.degenerate = 1'b1;
		end else begin
			dot = dot_acc;
			mag = dot < 0 ? -dot : dot;
			prod = norm_a_acc * norm_b_acc;
			q = cos_q14(mag, prod);
			r.similarity = dot < 0 ? -q : q;
			r.degenerate = 1'b0;
		end
		pending = {pending, r};
		dot_acc = '0;
		norm_a_acc = '0;
		norm_b_acc = '0;
	endfunction

	function void check_result(logic signed [15:0] sim, logic deg);
		result_t r;
		if (pending.size() == 0) begin
			$error("result with nothing expected: similarity %0d degenerate %0d", sim, deg);
			errors++;
			return;
		end
		r = pending.pop_front();
		results_seen++;
		if (r.degenerate) degenerate_seen++;
		if (r.similarity == 16384 || r.similarity == -16384) saturated_seen++;
		if (sim !== r.similarity) begin
			$error("similarity: expected %0d, actual %0d", r.similarity, sim);
			errors++;
		end
		if (deg !== r.degenerate) begin
			$error("degenerate: expected %0d, actual %0d", r.degenerate, deg);
			errors++;
		end
	endfunction
endclass

module tb_codebook_cosine_similarity_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS = 750;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic func = 1'b0;
	logic [7:0] entry_index = '0;
	logic signed [15:0] entry_value = '0;
	logic [7:0] code_a = '0;
	logic [7:0] code_b = '0;
	logic last = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [15:0] similarity;
	logic degenerate;

	ccs_scoreboard sb = new();
	bit calm = 1'b0;
	int n_sent = 0;
	int n_pairs = 0;
	int cycles = 0;
	int stall_left = 0;
	bit written [256];
	int live_codes [$];

	codebook_cosine_similarity_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.entry_index(entry_index), .entry_value(entry_value), .code_a(code_a),
		.code_b(code_b), .last(last), .empty(empty), .pop(pop),
		.similarity(similarity), .degenerate(degenerate)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: check on accept, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_result(similarity, degenerate);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= (stall_left == 1);
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 13);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_request(logic f, logic [7:0] idx, logic signed [15:0] val,
			logic [7:0] ca, logic [7:0] cb, logic lst);
		push <= 1'b1;
		func <= f;
		entry_index <= idx;
		entry_value <= val;
		code_a <= ca;
		code_b <= cb;
		last <= lst;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_request(f, idx, val, ca, cb, lst);
		n_sent++;
		if (f) n_pairs++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic write_entry(logic [7:0] idx, logic signed [15:0] val);
		send_request(1'b0, idx, val, 8'($urandom), 8'($urandom), 1'($urandom));
		if (!written[idx]) live_codes = {live_codes, int'(idx)};
		written[idx] = 1'b1;
	endtask

	task automatic send_pair(logic [7:0] ca, logic [7:0] cb, logic lst);
		send_request(1'b1, 8'($urandom), 16'($urandom), ca, cb, lst);
	endtask

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_vectors();
		int len, zero_side;
		logic [7:0] ca, cb;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
		zero_side = $urandom_range(0, 19);
		for (int i = 0; i < len; i++) begin
			ca = (zero_side == 0) ? 8'd0 :
				8'(live_codes[$urandom_range(0, live_codes.size() - 1)]);
			cb = (zero_side == 1) ? 8'd0 :
				8'(live_codes[$urandom_range(0, live_codes.size() - 1)]);
			if (zero_side == 2) cb = ca;
			send_pair(ca, cb, i == len - 1);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// entry 0 stays zero for the whole run
		write_entry(8'd0, 16'sd0);
		write_entry(8'd255, 16'sh8000);
		write_entry(8'd1, 16'sh7fff);
		write_entry(8'd127, -16'sd1);
		write_entry(8'd128, 16'sd1);
		send_request(1'b0, 8'd170, 16'sh5555, 8'hff, 8'h00, 1'b1);
		if (!written[170]) live_codes = {live_codes, 170};
		written[170] = 1'b1;
		send_pair(8'd1, 8'd1, 1'b1);
		send_pair(8'd1, 8'd255, 1'b1);
		send_pair(8'd0, 8'd1, 1'b1);
		send_pair(8'd255, 8'd0, 1'b1);
		send_pair(8'd0, 8'd0, 1'b1);
		send_pair(8'd255, 8'd255, 1'b0);
		send_pair(8'd127, 8'd128, 1'b1);
		send_pair(8'd255, 8'd1, 1'b0);
		send_pair(8'd170, 8'd127, 1'b0);
		send_pair(8'd128, 8'd255, 1'b1);
		send_pair(8'd0, 8'd170, 1'b0);
		send_pair(8'd127, 8'd0, 1'b1);

		while (n_sent < N_ITEMS) begin
			if (n_sent > N_ITEMS * 85 / 100) calm = 1'b1;
			if ($urandom_range(0, 3) == 0) write_entry(8'($urandom_range(1, 255)), rand_value());
			else send_vectors();
		end
		push <= 1'b0;
		calm = 1'b1;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d element pairs); checked %0d results,", n_sent,
			n_pairs, sb.results_seen);
		$display("%0d with zero norm and %0d at full scale.", sb.degenerate_seen,
			sb.saturated_seen);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_fifo.sv
hdl/ccs_back.sv
hdl/codebook_cosine_similarity_core.sv
tb/tb_codebook_cosine_similarity_core.sv
